FILE: hw/rtl/spsf_pkg.sv
package spsf_pkg;

    // Store sizing
    localparam int MAX_POINTS = 128;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Degree table for the pair sums
    localparam int DEG_N  = 128;
    localparam int DEG_AW = $clog2(DEG_N);

    // Datapath widths
    localparam int PS_W   = 2 * PT_AW + 33;
    localparam int MUL_W  = (PS_W - 13 > 34) ? PS_W - 13 : 34;
    localparam int WIDE_W = 2 * MUL_W;
    localparam int ACC_W  = 64;
    localparam int DIV_NW = 64;
    localparam int DIV_CW = $clog2(DIV_NW);
    localparam int DIV_DW = CNT_W + 14;
    localparam int REC_NB = 42;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_MODE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEGENDRE_DEGREE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAP_COSINE      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEGREE_LIMIT    = 2'd3;

    // Fixed-point constants
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [WIDE_W-1:0] P_HI   = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] P_LO   = WIDE_W'(-64'sd2147483648);
    localparam logic signed [WIDE_W-1:0] RES_HI = WIDE_W'(64'sd140737488355327);
    localparam logic signed [WIDE_W-1:0] RES_LO = WIDE_W'(-64'sd140737488355328);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct packed {
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic               last_point;
    } point_word_t;

    typedef struct packed {
        logic signed [47:0] result_value;
        logic               saturated;
        logic               points_dropped;
    } result_word_t;

    // Divide by 2^s, rounding to nearest with ties away from zero.
    function automatic logic signed [WIDE_W-1:0] round_shift(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              s
    );
        logic [WIDE_W-1:0] m;
        m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        m = m >> (s - 1);
        m = (m + WIDE_W'(1)) >> 1;
        return v[WIDE_W-1] ? -signed'(m) : signed'(m);
    endfunction

endpackage

FILE: hw/rtl/sphere_point_structure_factor.sv
// Points arrive one word per cycle and are written into a 128-entry store while the block
// is idle; a word marked last starts the computation and holds point_stall high until the
// result has been placed in the output register. The computation runs on one shared
// 34x34 multiplier and one shift-subtract divider (one quotient bit per cycle) under a
// sequencer. The Legendre step, with its division by k+1, is the bottleneck.
module sphere_point_structure_factor (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    point_valid,
    output logic                                    point_stall,
    input  spsf_pkg::point_word_t                   point_word,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output spsf_pkg::result_word_t                  result_word,
    input  logic                                    cfg_wen,
    input  logic [spsf_pkg::REG_IDX_W-1:0]          cfg_index,
    input  logic [spsf_pkg::CFG_W-1:0]              cfg_data
);
    import spsf_pkg::*;

    // Sequencer state codes
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RD_I    = 5'd1;
    localparam logic [4:0] ST_LD_I    = 5'd2;
    localparam logic [4:0] ST_RD_J    = 5'd3;
    localparam logic [4:0] ST_DOT0    = 5'd4;
    localparam logic [4:0] ST_DOT1    = 5'd5;
    localparam logic [4:0] ST_DOT2    = 5'd6;
    localparam logic [4:0] ST_DOT3    = 5'd7;
    localparam logic [4:0] ST_ACC_RD  = 5'd8;
    localparam logic [4:0] ST_ACC_WR  = 5'd9;
    localparam logic [4:0] ST_REC0    = 5'd10;
    localparam logic [4:0] ST_REC1    = 5'd11;
    localparam logic [4:0] ST_REC2    = 5'd12;
    localparam logic [4:0] ST_REC3    = 5'd13;
    localparam logic [4:0] ST_REC_DIV = 5'd14;
    localparam logic [4:0] ST_REC_END = 5'd15;
    localparam logic [4:0] ST_NEXT    = 5'd16;
    localparam logic [4:0] ST_F_START = 5'd17;
    localparam logic [4:0] ST_F0_RD   = 5'd18;
    localparam logic [4:0] ST_F0_D    = 5'd19;
    localparam logic [4:0] ST_F0_DIV  = 5'd20;
    localparam logic [4:0] ST_F0_END  = 5'd21;
    localparam logic [4:0] ST_F1_Q    = 5'd22;
    localparam logic [4:0] ST_F1_SQ   = 5'd23;
    localparam logic [4:0] ST_F1_PS   = 5'd24;
    localparam logic [4:0] ST_F1_MUL  = 5'd25;
    localparam logic [4:0] ST_F1_D    = 5'd26;
    localparam logic [4:0] ST_F1_DIV  = 5'd27;
    localparam logic [4:0] ST_F1_END  = 5'd28;
    localparam logic [4:0] ST_FIN     = 5'd29;
    localparam logic [4:0] ST_OUT     = 5'd30;

    localparam logic signed [37:0] DOT_HI = 38'sd1073741824;
    localparam logic signed [37:0] DOT_LO = -38'sd1073741824;

    // Control registers
    logic [4:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [PT_AW-1:0]       i_reg, i_next;
    logic [PT_AW-1:0]       j_reg, j_next;
    logic                   first_reg, first_next;
    logic                   final_reg, final_next;
    logic                   mode_reg, mode_next;
    logic [DEG_AW-1:0]      top_reg, top_next;
    logic [DEG_AW-1:0]      l_reg, l_next;
    logic                   result_valid_reg, result_valid_next;
    logic                   mode_cfg_reg, mode_cfg_next;
    logic [6:0]             degree_cfg_reg, degree_cfg_next;
    logic signed [15:0]     cap_cfg_reg, cap_cfg_next;
    logic [6:0]             limit_cfg_reg, limit_cfg_next;

    // Datapath registers
    point_t                 pi_reg, pi_next;
    logic signed [31:0]     pk_reg, pk_next;
    logic signed [31:0]     pkm1_reg, pkm1_next;
    logic signed [31:0]     pkm2_reg, pkm2_next;
    logic signed [31:0]     x_reg, x_next;
    logic signed [31:0]     val_reg, val_next;
    logic signed [MUL_W-1:0] t_reg, t_next;
    logic signed [WIDE_W-1:0] nacc_reg, nacc_next;
    logic signed [35:0]     dacc_reg, dacc_next;
    logic [24:0]            sq_reg, sq_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [WIDE_W-1:0] res_reg, res_next;
    logic                   neg_reg, neg_next;
    logic signed [WIDE_W-1:0] prod_reg;
    result_word_t           result_word_reg, result_word_next;

    // Shared divider
    logic [DIV_NW-1:0]      div_num_reg, div_num_next;
    logic [DIV_DW-1:0]      div_den_reg, div_den_next;
    logic [DIV_DW-1:0]      div_rem_reg, div_rem_next;
    logic [DIV_NW-1:0]      div_quo_reg, div_quo_next;
    logic [DIV_CW-1:0]      div_cnt_reg, div_cnt_next;

    // Memories
    point_t                 pt_mem [MAX_POINTS];
    point_t                 pt_rdata_reg;
    logic                   pt_we;
    logic [PT_AW-1:0]       pt_raddr;
    logic signed [PS_W-1:0] ps_mem [DEG_N];
    logic signed [PS_W-1:0] ps_rdata_reg;
    logic                   ps_we;
    logic [DEG_AW-1:0]      ps_raddr;
    logic signed [PS_W-1:0] ps_wdata;

    // Shared multiplier operands
    logic signed [MUL_W-1:0] mul_a, mul_b;

    // Combinational helpers
    logic                   point_take;
    logic                   result_take;
    logic signed [37:0]     dot_full;
    logic signed [31:0]     dot_clamp;
    logic signed [15:0]     cap_clamp;
    logic signed [31:0]     cap_q30;
    logic signed [WIDE_W-1:0] t_round;
    logic signed [WIDE_W-1:0] psr_round;
    logic signed [WIDE_W-1:0] fin_round;
    logic signed [WIDE_W-1:0] n_val;
    logic [WIDE_W-1:0]      n_mag;
    logic [WIDE_W-1:0]      prod_mag;
    logic [PS_W-1:0]        ps_mag;
    logic signed [WIDE_W-1:0] quo_signed;
    logic signed [31:0]     p_new;
    logic signed [32:0]     q_diff;
    logic [25:0]            sq_sum;
    logic [7:0]             k_plus1;
    logic [7:0]             k_odd;
    logic [DIV_DW:0]        div_trial;
    logic                   div_ge;
    logic signed [ACC_W-1:0] term;
    logic                   res_sat;
    logic signed [47:0]     res_clip;
    logic                   last_of_row;
    logic                   last_row;

    // Handshakes
    assign point_stall  = (state_reg != ST_IDLE);
    assign point_take   = point_valid && !point_stall;
    assign result_take  = result_valid_reg && !result_stall;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // Dot product, taken to Q2.30 and clamped to one
    assign dot_full  = (38'(dacc_reg) + 38'(signed'(prod_reg[33:0]))) <<< 2;
    assign dot_clamp = (dot_full > DOT_HI) ? ONE_Q30 :
                       (dot_full < DOT_LO) ? -ONE_Q30 : dot_full[31:0];

    // Cap cosine clamped to one and taken to Q2.30
    assign cap_clamp = (cap_cfg_reg > 16'sd16384)  ? 16'sd16384 :
                       (cap_cfg_reg < -16'sd16384) ? -16'sd16384 : cap_cfg_reg;
    assign cap_q30   = 32'(cap_clamp) <<< 16;

    // Roundings and magnitudes
    assign t_round   = round_shift(prod_reg, 30);
    assign psr_round = round_shift(WIDE_W'(ps_rdata_reg), 14);
    assign fin_round = round_shift(WIDE_W'(acc_reg), 22);
    assign n_val     = prod_reg + nacc_reg;
    assign n_mag     = n_val[WIDE_W-1] ? WIDE_W'(-n_val) : WIDE_W'(n_val);
    assign prod_mag  = prod_reg[WIDE_W-1] ? WIDE_W'(-prod_reg) : WIDE_W'(prod_reg);
    assign ps_mag    = ps_rdata_reg[PS_W-1] ? PS_W'(-ps_rdata_reg) : PS_W'(ps_rdata_reg);
    assign quo_signed = neg_reg ? -signed'(WIDE_W'(div_quo_reg))
                                : signed'(WIDE_W'(div_quo_reg));
    assign term      = neg_reg ? -signed'(div_quo_reg) : signed'(div_quo_reg);
    assign p_new     = (quo_signed > P_HI) ? 32'sh7fffffff :
                       (quo_signed < P_LO) ? -32'sh7fffffff - 32'sd1 : quo_signed[31:0];
    assign q_diff    = 33'(pk_reg) - 33'(pkm2_reg);
    assign sq_sum    = 26'(prod_reg[63:39]) + 26'd1;
    assign k_plus1   = {1'b0, l_reg} + 8'd1;
    assign k_odd     = {l_reg, 1'b1};

    // One restoring divider step
    assign div_trial = {div_rem_reg, div_num_reg[div_cnt_reg]};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});

    // Final saturation to 48 bits
    assign res_sat  = (res_reg > RES_HI) || (res_reg < RES_LO);
    assign res_clip = (res_reg > RES_HI) ? RES_HI[47:0] :
                      (res_reg < RES_LO) ? RES_LO[47:0] : res_reg[47:0];

    // Pair loop bounds
    assign last_of_row = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign last_row    = ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg);

    // Pair-sum accumulation: the first pair overwrites, later pairs add
    assign ps_wdata = first_reg ? PS_W'(val_reg) : ps_rdata_reg + PS_W'(val_reg);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        first_next        = first_reg;
        final_next        = final_reg;
        mode_next         = mode_reg;
        top_next          = top_reg;
        l_next            = l_reg;
        result_valid_next = result_valid_reg;
        mode_cfg_next     = mode_cfg_reg;
        degree_cfg_next   = degree_cfg_reg;
        cap_cfg_next      = cap_cfg_reg;
        limit_cfg_next    = limit_cfg_reg;
        pi_next           = pi_reg;
        pk_next           = pk_reg;
        pkm1_next         = pkm1_reg;
        pkm2_next         = pkm2_reg;
        x_next            = x_reg;
        val_next          = val_reg;
        t_next            = t_reg;
        nacc_next         = nacc_reg;
        dacc_next         = dacc_reg;
        sq_next           = sq_reg;
        acc_next          = acc_reg;
        res_next          = res_reg;
        neg_next          = neg_reg;
        result_word_next  = result_word_reg;
        div_num_next      = div_num_reg;
        div_den_next      = div_den_reg;
        div_rem_next      = div_rem_reg;
        div_quo_next      = div_quo_reg;
        div_cnt_next      = div_cnt_reg;
        mul_a             = '0;
        mul_b             = '0;
        pt_we             = 1'b0;
        pt_raddr          = j_reg;
        ps_we             = 1'b0;
        ps_raddr          = l_reg;

        // Configuration writes
        if (cfg_wen)
        begin
            case (cfg_index)
                REG_RESULT_MODE:     mode_cfg_next   = cfg_data[0];
                REG_LEGENDRE_DEGREE: degree_cfg_next = cfg_data[6:0];
                REG_CAP_COSINE:      cap_cfg_next    = signed'(cfg_data[15:0]);
                REG_DEGREE_LIMIT:    limit_cfg_next  = cfg_data[6:0];
                default:             ;
            endcase
        end

        // The output register empties when its word is taken
        if (result_take)
        begin
            result_valid_next = 1'b0;
        end

        // Shared divider steps
        if (state_reg inside {ST_REC_DIV, ST_F0_DIV, ST_F1_DIV})
        begin
            div_rem_next = div_ge ? DIV_DW'(div_trial - {1'b0, div_den_reg})
                                  : div_trial[DIV_DW-1:0];
            div_quo_next = {div_quo_reg[DIV_NW-2:0], div_ge};
            div_cnt_next = div_cnt_reg - DIV_CW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (point_take)
                begin
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        pt_we      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (point_word.last_point)
                    begin
                        state_next = ST_RD_I;
                        i_next     = '0;
                        j_next     = '0;
                        first_next = 1'b1;
                        final_next = 1'b0;
                        mode_next  = mode_cfg_reg;
                        top_next   = mode_cfg_reg ? limit_cfg_reg : degree_cfg_reg;
                    end
                end
            end

            // Fetch the row point, then the column point
            ST_RD_I:
            begin
                pt_raddr   = i_reg;
                state_next = ST_LD_I;
            end
            ST_LD_I:
            begin
                pi_next    = pt_rdata_reg;
                state_next = ST_DOT0;
            end
            ST_RD_J:
            begin
                state_next = ST_DOT0;
            end

            // Dot product over three multiplies
            ST_DOT0:
            begin
                mul_a      = MUL_W'(pi_reg.x);
                mul_b      = MUL_W'(pt_rdata_reg.x);
                state_next = ST_DOT1;
            end
            ST_DOT1:
            begin
                dacc_next  = 36'(signed'(prod_reg[33:0]));
                mul_a      = MUL_W'(pi_reg.y);
                mul_b      = MUL_W'(pt_rdata_reg.y);
                state_next = ST_DOT2;
            end
            ST_DOT2:
            begin
                dacc_next  = dacc_reg + 36'(signed'(prod_reg[33:0]));
                mul_a      = MUL_W'(pi_reg.z);
                mul_b      = MUL_W'(pt_rdata_reg.z);
                state_next = ST_DOT3;
            end
            ST_DOT3:
            begin
                x_next     = dot_clamp;
                pk_next    = dot_clamp;
                pkm1_next  = ONE_Q30;
                val_next   = ONE_Q30;
                l_next     = '0;
                state_next = ST_ACC_RD;
            end

            // Read-modify-write of the pair sum for degree l
            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                ps_we = 1'b1;
                if (l_reg == top_reg)
                begin
                    state_next = ST_NEXT;
                end
                else if (l_reg == '0)
                begin
                    l_next     = DEG_AW'(1);
                    val_next   = pk_reg;
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    state_next = ST_REC0;
                end
            end

            // Bonnet step: P(k+1) from P(k) and P(k-1), k = l
            ST_REC0:
            begin
                pkm2_next  = pkm1_reg;
                mul_a      = MUL_W'(x_reg);
                mul_b      = MUL_W'(pk_reg);
                state_next = ST_REC1;
            end
            ST_REC1:
            begin
                t_next     = t_round[MUL_W-1:0];
                mul_a      = MUL_W'(l_reg);
                mul_b      = MUL_W'(pkm1_reg);
                state_next = ST_REC2;
            end
            ST_REC2:
            begin
                nacc_next  = -prod_reg;
                mul_a      = MUL_W'(k_odd);
                mul_b      = t_reg;
                state_next = ST_REC3;
            end
            ST_REC3:
            begin
                neg_next     = n_val[WIDE_W-1];
                div_num_next = n_mag[DIV_NW-1:0] + DIV_NW'(k_plus1 >> 1);
                div_den_next = DIV_DW'(k_plus1);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DIV_CW'(REC_NB - 1);
                state_next   = ST_REC_DIV;
            end
            ST_REC_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_REC_END;
                end
            end
            ST_REC_END:
            begin
                pkm1_next = pk_reg;
                pk_next   = p_new;
                if (final_reg)
                begin
                    state_next = ST_F1_Q;
                end
                else
                begin
                    val_next   = p_new;
                    l_next     = l_reg + DEG_AW'(1);
                    state_next = ST_ACC_RD;
                end
            end

            // Advance to the next ordered pair
            ST_NEXT:
            begin
                first_next = 1'b0;
                if (last_of_row)
                begin
                    j_next = '0;
                    if (last_row)
                    begin
                        state_next = ST_F_START;
                    end
                    else
                    begin
                        i_next     = i_reg + PT_AW'(1);
                        state_next = ST_RD_I;
                    end
                end
                else
                begin
                    j_next     = j_reg + PT_AW'(1);
                    state_next = ST_RD_J;
                end
            end

            ST_F_START:
            begin
                final_next = 1'b1;
                acc_next   = '0;
                if (!mode_reg)
                begin
                    state_next = ST_F0_RD;
                end
                else
                begin
                    x_next    = cap_q30;
                    pk_next   = cap_q30;
                    pkm1_next = ONE_Q30;
                    if (top_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        l_next     = DEG_AW'(1);
                        state_next = ST_REC0;
                    end
                end
            end

            // Structure factor: pair sum over N * 2^14
            ST_F0_RD:
            begin
                ps_raddr   = top_reg;
                state_next = ST_F0_D;
            end
            ST_F0_D:
            begin
                neg_next     = ps_rdata_reg[PS_W-1];
                div_den_next = {count_reg, 14'd0};
                div_num_next = DIV_NW'(ps_mag) + DIV_NW'({count_reg, 13'd0});
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DIV_CW'(DIV_NW - 1);
                state_next   = ST_F0_DIV;
            end
            ST_F0_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_F0_END;
                end
            end
            ST_F0_END:
            begin
                res_next   = quo_signed;
                state_next = ST_OUT;
            end

            // Number variance: one term per degree
            ST_F1_Q:
            begin
                mul_a      = MUL_W'(q_diff);
                mul_b      = MUL_W'(q_diff);
                state_next = ST_F1_SQ;
            end
            ST_F1_SQ:
            begin
                sq_next    = sq_sum[25:1];
                state_next = ST_F1_PS;
            end
            ST_F1_PS:
            begin
                t_next     = psr_round[MUL_W-1:0];
                state_next = ST_F1_MUL;
            end
            ST_F1_MUL:
            begin
                mul_a      = t_reg;
                mul_b      = MUL_W'(sq_reg);
                state_next = ST_F1_D;
            end
            ST_F1_D:
            begin
                neg_next     = prod_reg[WIDE_W-1];
                div_num_next = prod_mag[DIV_NW-1:0] + DIV_NW'(l_reg);
                div_den_next = DIV_DW'(k_odd);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DIV_CW'(DIV_NW - 1);
                state_next   = ST_F1_DIV;
            end
            ST_F1_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_F1_END;
                end
            end
            ST_F1_END:
            begin
                acc_next = acc_reg + term;
                if (l_reg == top_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    l_next     = l_reg + DEG_AW'(1);
                    state_next = ST_REC0;
                end
            end
            ST_FIN:
            begin
                res_next   = fin_round;
                state_next = ST_OUT;
            end

            // Hand the result to the output register once it is free
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next                = 1'b1;
                    result_word_next.result_value    = res_clip;
                    result_word_next.saturated       = res_sat;
                    result_word_next.points_dropped  = ovf_reg;
                    count_next                       = '0;
                    ovf_next                         = 1'b0;
                    state_next                       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            first_reg        <= 1'b0;
            final_reg        <= 1'b0;
            mode_reg         <= 1'b0;
            top_reg          <= '0;
            l_reg            <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            mode_cfg_reg     <= 1'b0;
            degree_cfg_reg   <= 7'd1;
            cap_cfg_reg      <= 16'sd16384;
            limit_cfg_reg    <= 7'd100;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            first_reg        <= first_next;
            final_reg        <= final_next;
            mode_reg         <= mode_next;
            top_reg          <= top_next;
            l_reg            <= l_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
            mode_cfg_reg     <= mode_cfg_next;
            degree_cfg_reg   <= degree_cfg_next;
            cap_cfg_reg      <= cap_cfg_next;
            limit_cfg_reg    <= limit_cfg_next;
        end
    end

    // Datapath registers and the shared multiplier
    always_ff @(posedge clk)
    begin
        pi_reg          <= pi_next;
        pk_reg          <= pk_next;
        pkm1_reg        <= pkm1_next;
        pkm2_reg        <= pkm2_next;
        x_reg           <= x_next;
        val_reg         <= val_next;
        t_reg           <= t_next;
        nacc_reg        <= nacc_next;
        dacc_reg        <= dacc_next;
        sq_reg          <= sq_next;
        acc_reg         <= acc_next;
        res_reg         <= res_next;
        neg_reg         <= neg_next;
        result_word_reg <= result_word_next;
        div_num_reg     <= div_num_next;
        div_den_reg     <= div_den_next;
        div_rem_reg     <= div_rem_next;
        div_quo_reg     <= div_quo_next;
        prod_reg        <= mul_a * mul_b;
    end

    // Point store
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[count_reg[PT_AW-1:0]] <= {point_word.coord_x, point_word.coord_y,
                                             point_word.coord_z};
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
    end

    // Pair sums, one per degree
    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[l_reg] <= ps_wdata;
        end
        ps_rdata_reg <= ps_mem[ps_raddr];
    end

    // The fill count never passes the store depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // A word marked last always starts the pair loop.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (point_take && point_word.last_point) |=> (state_reg == ST_RD_I))
        else $error("last word did not start the computation");

    // A result word appears only from the hand-over state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside hand-over");

    // The degree being accumulated stays within the degree in use.
    a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC_WR) |-> (l_reg <= top_reg))
        else $error("accumulated degree beyond limit");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// Scoreboard for the structure factor block: keeps its own copy of the point
// store and registers, predicts the result word of each set and compares it.
class structure_factor_scoreboard;

    spsf_pkg::point_t       stored_points[spsf_pkg::MAX_POINTS];
    int                     stored_count;
    bit                     store_overflowed;
    bit                     mode_variance;
    int                     sf_degree;
    logic [15:0]            cap_cos_raw;
    int                     variance_degrees;
    spsf_pkg::result_word_t pending_results[$];
    int                     failures;

    function new();
        stored_count     = 0;
        store_overflowed = 0;
        mode_variance    = 0;
        sf_degree        = 1;
        cap_cos_raw      = 16'd16384;
        variance_degrees = 100;
        failures         = 0;
    endfunction

    function void note_register(logic [spsf_pkg::REG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            spsf_pkg::REG_RESULT_MODE:     mode_variance    = data[0];
            spsf_pkg::REG_LEGENDRE_DEGREE: sf_degree        = data[6:0];
            spsf_pkg::REG_CAP_COSINE:      cap_cos_raw      = data;
            spsf_pkg::REG_DEGREE_LIMIT:    variance_degrees = data[6:0];
            default: ;
        endcase
    endfunction

    // Rounded division by 2^s, ties away from zero.
    function longint round_pow2(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = ((m >> (s - 1)) + 1) >> 1;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Rounded division by a positive integer, ties away from zero.
    function longint round_div(longint n, longint unsigned d);
        longint unsigned m;
        m = (n < 0) ? longint'(-n) : n;
        m = (m + d / 2) / d;
        return (n < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Bonnet recurrence in Q2.30, each value saturated to 32 bits.
    function void legendre_series(longint x, int top, ref longint p[0:128]);
        longint t;
        longint n;
        p[0] = longint'(1) << 30;
        if (top >= 1)
            p[1] = x;
        for (int k = 1; k < top; k++)
        begin
            t = round_pow2(x * p[k], 30);
            n = longint'(2 * k + 1) * t - longint'(k) * p[k - 1];
            p[k + 1] = clip(round_div(n, k + 1), -(longint'(1) << 31),
                            (longint'(1) << 31) - 1);
        end
    endfunction

    // Accepted point word: store it and, on the last word, predict the result.
    function void note_point(spsf_pkg::point_word_t w);
        longint                 pair_sum[0:128];
        longint                 pv[0:128];
        longint                 pc[0:128];
        longint                 dot;
        longint                 acc;
        longint                 res;
        longint unsigned        qm;
        longint                 sq;
        int                     top;
        spsf_pkg::result_word_t r;
        if (stored_count < spsf_pkg::MAX_POINTS)
        begin
            stored_points[stored_count] = {w.coord_x, w.coord_y, w.coord_z};
            stored_count++;
        end
        else
            store_overflowed = 1;
        if (!w.last_point)
            return;
        top = mode_variance ? variance_degrees : sf_degree;
        foreach (pair_sum[l])
            pair_sum[l] = 0;
        for (int i = 0; i < stored_count; i++)
            for (int j = 0; j < stored_count; j++)
            begin
                dot = longint'(stored_points[i].x) * stored_points[j].x
                    + longint'(stored_points[i].y) * stored_points[j].y
                    + longint'(stored_points[i].z) * stored_points[j].z;
                dot = clip(dot * 4, -(longint'(1) << 30), longint'(1) << 30);
                legendre_series(dot, top, pv);
                for (int l = 0; l <= top; l++)
                    pair_sum[l] += pv[l];
            end
        if (!mode_variance)
            res = round_div(pair_sum[top], longint'(stored_count) << 14);
        else
        begin
            acc = 0;
            legendre_series(clip(longint'($signed(cap_cos_raw)), -16384, 16384) * 65536,
                            128, pc);
            for (int l = 1; l <= top; l++)
            begin
                qm = (pc[l + 1] - pc[l - 1] < 0) ? longint'(pc[l - 1] - pc[l + 1])
                                                 : longint'(pc[l + 1] - pc[l - 1]);
                sq = longint'((((qm * qm) >> 39) + 1) >> 1);
                acc += round_div(round_pow2(pair_sum[l], 14) * sq, 2 * l + 1);
            end
            res = round_pow2(acc, 22);
        end
        r.saturated = 0;
        if (res > (longint'(1) << 47) - 1)
        begin
            res         = (longint'(1) << 47) - 1;
            r.saturated = 1;
        end
        if (res < -(longint'(1) << 47))
        begin
            res         = -(longint'(1) << 47);
            r.saturated = 1;
        end
        r.result_value   = res[47:0];
        r.points_dropped = store_overflowed;
        pending_results.push_back(r);
        stored_count     = 0;
        store_overflowed = 0;
    endfunction

    // Accepted result word: compare with the oldest prediction.
    function void check_result(spsf_pkg::result_word_t got);
        spsf_pkg::result_word_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, got);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        if (got.result_value !== want.result_value)
        begin
            $display("%0t: result_value expected %0d got %0d", $time,
                     want.result_value, got.result_value);
            failures++;
        end
        if (got.saturated !== want.saturated)
        begin
            $display("%0t: saturated expected %0b got %0b", $time,
                     want.saturated, got.saturated);
            failures++;
        end
        if (got.points_dropped !== want.points_dropped)
        begin
            $display("%0t: points_dropped expected %0b got %0b", $time,
                     want.points_dropped, got.points_dropped);
            failures++;
        end
    endfunction

endclass

module testbench;

    localparam int QUIET_LIMIT = 2000000;

    logic                                clk;
    logic                                rst_n;
    logic                                point_valid;
    logic                                point_stall;
    spsf_pkg::point_word_t               point_word;
    logic                                result_valid;
    logic                                result_stall;
    spsf_pkg::result_word_t              result_word;
    logic                                cfg_wen;
    logic [spsf_pkg::REG_IDX_W-1:0]      cfg_index;
    logic [spsf_pkg::CFG_W-1:0]          cfg_data;

    structure_factor_scoreboard sb;
    bit                         steady_flow;
    int                         quiet_cycles;
    int                         points_sent;

    sphere_point_structure_factor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_word   (point_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Result side: check accepted words, stall at random, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result_word);
            if ((result_valid && !result_stall) || (point_valid && !point_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
        result_stall <= !steady_flow && ($urandom_range(99) < 24);
    end

    // Send one point word, idling at random beforehand.
    task automatic send_point(input spsf_pkg::point_word_t w);
        while (!steady_flow && $urandom_range(99) < 24)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_word  <= w;
        do
            @(posedge clk);
        while (point_stall);
        sb.note_point(w);
        points_sent++;
    endtask

    task automatic send_coords(input logic [15:0] x, y, z, input bit last);
        spsf_pkg::point_word_t w;
        w.coord_x    = x;
        w.coord_y    = y;
        w.coord_z    = z;
        w.last_point = last;
        send_point(w);
    endtask

    // Random coordinate: mostly within the unit range, sometimes any 16-bit value.
    function automatic logic [15:0] random_coord();
        if ($urandom_range(3) == 0)
            return 16'($urandom());
        return 16'($urandom_range(32768) - 16384);
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_coords(random_coord(), random_coord(), random_coord(), i == n - 1);
    endtask

    // Hold off until every predicted result has come back and the block is idle.
    task automatic wait_drained();
        @(posedge clk);
        point_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [spsf_pkg::REG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.note_register(idx, data);
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input bit mode, input int deg, input logic [15:0] cap,
                             input int limit);
        wait_drained();
        write_reg(spsf_pkg::REG_RESULT_MODE, 16'(mode));
        write_reg(spsf_pkg::REG_LEGENDRE_DEGREE, 16'(deg));
        write_reg(spsf_pkg::REG_CAP_COSINE, cap);
        write_reg(spsf_pkg::REG_DEGREE_LIMIT, 16'(limit));
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        point_valid  = 1'b0;
        point_word   = '0;
        result_stall = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady_flow  = 1'b0;
        quiet_cycles = 0;
        points_sent  = 0;
        sb           = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: structure factor of degree one on a single pole.
        send_coords(16'd16384, 16'd0, 16'd0, 1'b1);
        // Coordinate extremes, including words whose dot products need clamping.
        send_coords(16'hC000, 16'd16384, 16'd0, 1'b0);
        send_coords(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_coords(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_coords(16'd0, 16'd0, 16'hC000, 1'b1);
        // Degree zero, then the highest degree.
        configure(1'b0, 0, 16'd16384, 100);
        send_set(2);
        configure(1'b0, 127, 16'd16384, 100);
        send_set(1);
        // Number variance at the cap extremes and with cosines beyond one.
        configure(1'b1, 1, 16'd16384, 100);
        send_set(2);
        configure(1'b1, 1, 16'hC000, 127);
        send_set(1);
        configure(1'b1, 1, 16'h7FFF, 3);
        send_set(3);
        configure(1'b1, 1, 16'h8000, 0);
        send_set(2);
        // Store overflow: the extra points are dropped and flagged.
        configure(1'b0, 1, 16'd0, 1);
        send_set(spsf_pkg::MAX_POINTS + 3);

        // Random phases of small sets under changing settings.
        for (int phase = 0; points_sent < 600; phase++)
        begin
            configure($urandom_range(1), ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8),
                      $urandom(), $urandom_range(8));
            steady_flow = (phase >= 20 && phase < 30);
            repeat (4) send_set($urandom_range(1, 4));
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
